### hw/rtl/sfc_pkg.sv
// Package: constants, register codes and sine table for the swept comb flanger.
package sfc_pkg;

    localparam int COMB_DEPTH       = 4096;
    localparam int SAMPLE_BITS      = 24;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int ADDR_BITS     = $clog2(COMB_DEPTH);
    localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_BITS    = 24;
    localparam int DELAY_BITS    = 12;
    localparam int GAIN_BITS     = 15;
    localparam int MIX_BITS      = 16;
    localparam int SINE_BITS     = 16;
    localparam int MOD_BITS      = 31;
    localparam int FACT_BITS     = 31;
    localparam int DPROD_BITS    = DELAY_BITS + FACT_BITS;
    localparam int RAW_BITS      = DPROD_BITS - 30;
    localparam int WIDE_BITS     = SAMPLE_BITS + 18;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_LEFT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOD_DEPTH     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIX_GAIN      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LFO_STEP      = 3'd5;

    localparam logic [MIX_BITS-1:0]        MIX_ONE   = 16'd32768;
    localparam logic signed [MOD_BITS:0]   ONE_Q30   = 32'sd1073741824;
    localparam logic signed [WIDE_BITS-1:0] RND_HALF = WIDE_BITS'(16384);
    localparam logic signed [WIDE_BITS-1:0] SMAX_W   =
        (WIDE_BITS'(1) <<< (SAMPLE_BITS - 1)) - WIDE_BITS'(1);
    localparam logic signed [WIDE_BITS-1:0] SMIN_W   = -SMAX_W - WIDE_BITS'(1);

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    typedef logic signed [SINE_BITS-1:0] sine_t;
    typedef sine_t sine_rom_t [SINE_TABLE_DEPTH];

    // Q2.30 Taylor series with quarter-wave folding
    function automatic sine_t sine_entry(input int unsigned k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] negs;
        logic [63:0] s;
        logic [63:0] v;
        logic        neg;
        int          n;
        a = (64'(k) * TWO_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        neg = 1'b0;
        if (a >= PI_Q30)
        begin
            neg = 1'b1;
            a = a - PI_Q30;
        end
        if (a > HALF_PI_Q30)
        begin
            a = PI_Q30 - a;
        end
        a2 = (a * a) >> 30;
        term = a;
        pos = a;
        negs = 64'd0;
        for (n = 1; n <= 8; n++)
        begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
            begin
                negs = negs + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        s = (pos > negs) ? (pos - negs) : 64'd0;
        v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return neg ? -sine_t'(v[SINE_BITS-1:0]) : sine_t'(v[SINE_BITS-1:0]);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t r;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            r[k] = sine_entry(k);
        end
        return r;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [WIDE_BITS-1:0] x
    );
        logic signed [WIDE_BITS-1:0] y;
        y = x;
        if (x > SMAX_W)
        begin
            y = SMAX_W;
        end
        else if (x < SMIN_W)
        begin
            y = SMIN_W;
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

endpackage

### hw/rtl/sfc_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
module sfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/stereo_swept_comb_flanger.sv
// Top level: LFO-swept stereo feedback comb flanger.
// Input channel: in_valid/in_stall with left_sample, right_sample (one stereo item).
// Output channel: out_valid/out_stall with left_out, right_out (one item per input).
// Config channel: cfg_valid/cfg_ready with cfg_index, cfg_data; cfg_ready is always
// high, writes belong in idle periods. Unknown indexes are ignored.
// Each item walks a 7-state sequencer: phase step, sine table read, depth multiply,
// delay multiply, ring read, gain multiplies, write-back. A new item is taken only
// once the sequencer is idle again, and out_valid rises once the write-back state
// retires the item. The sequencer makes a single read and single write per ring RAM per item.
// A new item is accepted while the previous result still waits in the output
// register; the write-back state holds while out_stall keeps that result pending.
// Reset returns the config registers to defaults, phase and write pointer to zero.
// The rings need no clearing pass: a fill count marks unwritten entries, read as zero.
module stereo_swept_comb_flanger
    import sfc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SINE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_DELAY = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    localparam logic [ADDR_BITS:0] FILL_FULL = (ADDR_BITS+1)'(COMB_DEPTH);

    // config registers
    logic [DELAY_BITS-1:0] delay_left_reg;
    logic [DELAY_BITS-1:0] delay_right_reg;
    logic [GAIN_BITS-1:0]  feedback_gain_reg;
    logic [GAIN_BITS-1:0]  mod_depth_reg;
    logic [MIX_BITS-1:0]   mix_gain_reg;
    logic [PHASE_BITS-1:0] lfo_step_reg;

    // control state
    logic [2:0]            state_reg, state_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [ADDR_BITS-1:0]  wi_reg, wi_next;
    logic [ADDR_BITS:0]    fill_reg, fill_next;
    logic                  out_valid_reg, out_valid_next;

    // datapath registers
    logic signed [SAMPLE_BITS-1:0] dry_l_reg, dry_r_reg;
    sine_t                         sine_reg;
    logic signed [MOD_BITS-1:0]    mod_reg;
    logic [DPROD_BITS-1:0]         dprod_l_reg, dprod_r_reg;
    logic                          vld_l_reg, vld_r_reg;
    logic signed [WIDE_BITS-1:0]   fbp_l_reg, fbp_r_reg;
    logic signed [WIDE_BITS-1:0]   dryp_l_reg, dryp_r_reg;
    logic signed [WIDE_BITS-1:0]   wetp_l_reg, wetp_r_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;

    logic                          accept;
    logic                          retire;
    logic signed [MOD_BITS:0]      fact_l, fact_r;
    logic [ADDR_BITS-1:0]          d_l, d_r;
    logic [ADDR_BITS-1:0]          raddr_l, raddr_r;
    logic                          re;
    logic [SAMPLE_BITS-1:0]        rdata_l, rdata_r;
    logic signed [SAMPLE_BITS-1:0] c_l, c_r;
    logic [MIX_BITS-1:0]           mix_eff;
    logic signed [MIX_BITS:0]      mix_s, dry_w_s;
    logic signed [GAIN_BITS:0]     fb_s;
    logic signed [SAMPLE_BITS-1:0] wdata_l, wdata_r;

    function automatic logic [ADDR_BITS-1:0] clamp_delay(input logic [RAW_BITS-1:0] raw);
        logic [31:0] w;
        w = 32'(raw);
        if (w == 32'd0)
        begin
            w = 32'd1;
        end
        else if (w > 32'(COMB_DEPTH - 1))
        begin
            w = 32'(COMB_DEPTH - 1);
        end
        return w[ADDR_BITS-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign retire    = (state_reg == ST_WRITE) && (!out_valid_reg || !out_stall);

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    assign fact_l = ONE_Q30 + (MOD_BITS+1)'(mod_reg);
    assign fact_r = ONE_Q30 - (MOD_BITS+1)'(mod_reg);

    assign d_l     = clamp_delay(dprod_l_reg[DPROD_BITS-1:30]);
    assign d_r     = clamp_delay(dprod_r_reg[DPROD_BITS-1:30]);
    assign raddr_l = wi_reg - d_l;
    assign raddr_r = wi_reg - d_r;
    assign re      = (state_reg == ST_ADDR);

    assign c_l = vld_l_reg ? signed'(rdata_l) : '0;
    assign c_r = vld_r_reg ? signed'(rdata_r) : '0;

    assign mix_eff = (mix_gain_reg > MIX_ONE) ? MIX_ONE : mix_gain_reg;
    assign mix_s   = signed'({1'b0, mix_eff});
    assign dry_w_s = signed'({1'b0, MIX_ONE - mix_eff});
    assign fb_s    = signed'({1'b0, feedback_gain_reg});

    assign wdata_l = sat_sample(WIDE_BITS'(dry_l_reg) + ((fbp_l_reg + RND_HALF) >>> 15));
    assign wdata_r = sat_sample(WIDE_BITS'(dry_r_reg) + ((fbp_r_reg + RND_HALF) >>> 15));

    sfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (COMB_DEPTH)
    ) u_ring_left (
        .clk   (clk),
        .we    (retire),
        .waddr (wi_reg),
        .wdata (wdata_l),
        .re    (re),
        .raddr (raddr_l),
        .rdata (rdata_l)
    );

    sfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (COMB_DEPTH)
    ) u_ring_right (
        .clk   (clk),
        .we    (retire),
        .waddr (wi_reg),
        .wdata (wdata_r),
        .re    (re),
        .raddr (raddr_r),
        .rdata (rdata_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        wi_next        = wi_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    phase_next = phase_reg + lfo_step_reg;
                    state_next = ST_SINE;
                end
            end
            ST_SINE:  state_next = ST_MOD;
            ST_MOD:   state_next = ST_DELAY;
            ST_DELAY: state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (retire)
                begin
                    out_valid_next = 1'b1;
                    wi_next        = wi_reg + 1'b1;
                    if (fill_reg != FILL_FULL)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= '0;
            wi_reg            <= '0;
            fill_reg          <= '0;
            out_valid_reg     <= 1'b0;
            delay_left_reg    <= 12'd240;
            delay_right_reg   <= 12'd336;
            feedback_gain_reg <= 15'd19661;
            mod_depth_reg     <= 15'd26214;
            mix_gain_reg      <= 16'd16384;
            lfo_step_reg      <= 24'd70;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wi_reg        <= wi_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DELAY_LEFT:    delay_left_reg    <= cfg_data[DELAY_BITS-1:0];
                    REG_DELAY_RIGHT:   delay_right_reg   <= cfg_data[DELAY_BITS-1:0];
                    REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[GAIN_BITS-1:0];
                    REG_MOD_DEPTH:     mod_depth_reg     <= cfg_data[GAIN_BITS-1:0];
                    REG_MIX_GAIN:      mix_gain_reg      <= cfg_data[MIX_BITS-1:0];
                    REG_LFO_STEP:      lfo_step_reg      <= cfg_data[PHASE_BITS-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dry_l_reg <= left_sample;
            dry_r_reg <= right_sample;
        end
        if (state_reg == ST_SINE)
        begin
            sine_reg <= SINE_ROM[phase_reg[PHASE_BITS-1 -: SINE_IDX_BITS]];
        end
        if (state_reg == ST_MOD)
        begin
            mod_reg <= MOD_BITS'(sine_reg * signed'({1'b0, mod_depth_reg}));
        end
        if (state_reg == ST_DELAY)
        begin
            dprod_l_reg <= DPROD_BITS'(delay_left_reg) * DPROD_BITS'(fact_l[FACT_BITS-1:0]);
            dprod_r_reg <= DPROD_BITS'(delay_right_reg) * DPROD_BITS'(fact_r[FACT_BITS-1:0]);
        end
        if (state_reg == ST_ADDR)
        begin
            vld_l_reg <= (fill_reg >= {1'b0, d_l});
            vld_r_reg <= (fill_reg >= {1'b0, d_r});
        end
        if (state_reg == ST_MUL)
        begin
            fbp_l_reg  <= WIDE_BITS'(c_l * fb_s);
            fbp_r_reg  <= WIDE_BITS'(c_r * fb_s);
            wetp_l_reg <= WIDE_BITS'(c_l * mix_s);
            wetp_r_reg <= WIDE_BITS'(c_r * mix_s);
            dryp_l_reg <= WIDE_BITS'(dry_l_reg * dry_w_s);
            dryp_r_reg <= WIDE_BITS'(dry_r_reg * dry_w_s);
        end
        if (retire)
        begin
            left_out_reg  <= sat_sample((dryp_l_reg + wetp_l_reg + RND_HALF) >>> 15);
            right_out_reg <= sat_sample((dryp_r_reg + wetp_r_reg + RND_HALF) >>> 15);
        end
    end

endmodule

### sim/stereo_swept_comb_flanger_tb.sv
// Testbench for stereo_swept_comb_flanger: item-level predictor, random handshakes and config sweeps.
module stereo_swept_comb_flanger_tb
    import sfc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int SEGMENTS      = 8;
    localparam int SEG_ITEMS     = 250;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE_HI = 3'd7;

    localparam logic [DELAY_BITS-1:0] DEF_DELAY_L = 12'd240;
    localparam logic [DELAY_BITS-1:0] DEF_DELAY_R = 12'd336;
    localparam logic [GAIN_BITS-1:0]  DEF_FB      = 15'd19661;
    localparam logic [GAIN_BITS-1:0]  DEF_DEPTH   = 15'd26214;
    localparam logic [MIX_BITS-1:0]   DEF_MIX     = 16'd16384;
    localparam logic [PHASE_BITS-1:0] DEF_STEP    = 24'd70;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint Q30_UNITY  = longint'(1) << 30;
    localparam longint WET_FULL   = 32768;
    localparam longint ROUND_HALF = 16384;

    localparam longint unsigned ANG_PI      = 64'd3373259426;
    localparam longint unsigned ANG_HALF_PI = 64'd1686629713;
    localparam longint unsigned ANG_TWO_PI  = 64'd6746518852;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAMPLE_MAX[SAMPLE_BITS-1:0];
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAMPLE_MIN[SAMPLE_BITS-1:0];

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } stereo_pair_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] left_sample = '0;
    logic signed [SAMPLE_BITS-1:0] right_sample = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

    // predictor state
    logic signed [15:0]            sine_lut [SINE_TABLE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] ring_l [COMB_DEPTH];
    logic signed [SAMPLE_BITS-1:0] ring_r [COMB_DEPTH];
    logic [ADDR_BITS-1:0]          wr_ptr;
    logic [PHASE_BITS-1:0]         lfo_acc;
    logic [DELAY_BITS-1:0]         cfg_delay_l;
    logic [DELAY_BITS-1:0]         cfg_delay_r;
    logic [GAIN_BITS-1:0]          cfg_fb;
    logic [GAIN_BITS-1:0]          cfg_depth;
    logic [MIX_BITS-1:0]           cfg_mix;
    logic [PHASE_BITS-1:0]         cfg_step;

    stereo_pair_t pending_pairs[$];
    stereo_pair_t expected_pairs[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int reg_writes     = 0;
    int setting_count  = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 32;
    int recv_stall_pct = 67;
    int hold_request   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    stereo_swept_comb_flanger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Q2.30 Taylor series, folded to the first quarter wave
    function automatic logic signed [15:0] sine_q15(input int k);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned up;
        longint unsigned down;
        longint unsigned mag;
        longint unsigned q;
        logic signed [15:0] r;
        bit lower;
        ang = (longint'(k) * ANG_TWO_PI) / SINE_TABLE_DEPTH;
        lower = (ang >= ANG_PI);
        if (lower)
        begin
            ang = ang - ANG_PI;
        end
        if (ang > ANG_HALF_PI)
        begin
            ang = ANG_PI - ang;
        end
        ang2 = (ang * ang) >> 30;
        term = ang;
        up = ang;
        down = 0;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                down += term;
            end
            else
            begin
                up += term;
            end
        end
        mag = (up > down) ? up - down : 0;
        q = (mag * 32767 + (longint'(1) << 29)) >> 30;
        if (q > 32767)
        begin
            q = 32767;
        end
        r = q[15:0];
        return lower ? -r : r;
    endfunction

    function automatic longint rnd15(input longint x);
        return (x + ROUND_HALF) >>> 15;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clip(input longint x);
        longint y;
        y = x;
        if (y > SAMPLE_MAX)
        begin
            y = SAMPLE_MAX;
        end
        if (y < SAMPLE_MIN)
        begin
            y = SAMPLE_MIN;
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    function automatic longint clamp_delay(input longint d);
        if (d < 1)
        begin
            return 1;
        end
        if (d > COMB_DEPTH - 1)
        begin
            return COMB_DEPTH - 1;
        end
        return d;
    endfunction

    function automatic void apply_reg(
        input logic [CFG_IDX_BITS-1:0]  idx,
        input logic [CFG_DATA_BITS-1:0] d
    );
        case (idx)
            REG_DELAY_LEFT:    cfg_delay_l = d[DELAY_BITS-1:0];
            REG_DELAY_RIGHT:   cfg_delay_r = d[DELAY_BITS-1:0];
            REG_FEEDBACK_GAIN: cfg_fb = d[GAIN_BITS-1:0];
            REG_MOD_DEPTH:     cfg_depth = d[GAIN_BITS-1:0];
            REG_MIX_GAIN:      cfg_mix = d[MIX_BITS-1:0];
            REG_LFO_STEP:      cfg_step = d[PHASE_BITS-1:0];
            default: ;
        endcase
    endfunction

    // advance the flanger by one stereo item and queue the expected output
    function automatic void flange_step(
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r
    );
        longint dry_l;
        longint dry_r;
        longint sw;
        longint m;
        longint fb;
        longint mix;
        longint base_l;
        longint base_r;
        longint dl;
        longint dr;
        longint cl;
        longint cr;
        logic [ADDR_BITS-1:0] rd_l;
        logic [ADDR_BITS-1:0] rd_r;
        stereo_pair_t res;
        dry_l = l;
        dry_r = r;
        fb = cfg_fb;
        base_l = cfg_delay_l;
        base_r = cfg_delay_r;
        mix = cfg_mix;
        if (mix > WET_FULL)
        begin
            mix = WET_FULL;
        end
        lfo_acc = lfo_acc + cfg_step;
        sw = sine_lut[lfo_acc[PHASE_BITS-1 -: SINE_IDX_BITS]];
        m = sw * longint'(cfg_depth);
        dl = clamp_delay((base_l * (Q30_UNITY + m)) >>> 30);
        dr = clamp_delay((base_r * (Q30_UNITY - m)) >>> 30);
        rd_l = wr_ptr - ADDR_BITS'(dl);
        rd_r = wr_ptr - ADDR_BITS'(dr);
        cl = ring_l[rd_l];
        cr = ring_r[rd_r];
        ring_l[wr_ptr] = clip(dry_l + rnd15(cl * fb));
        ring_r[wr_ptr] = clip(dry_r + rnd15(cr * fb));
        res.left = clip(rnd15(dry_l * (WET_FULL - mix) + cl * mix));
        res.right = clip(rnd15(dry_r * (WET_FULL - mix) + cr * mix));
        expected_pairs.push_back(res);
        wr_ptr = wr_ptr + 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(19))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(7))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic queue_item(
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r
    );
        stereo_pair_t p;
        p.left = l;
        p.right = r;
        pending_pairs.push_back(p);
        queued_count++;
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_BITS-1:0]  idx,
        input logic [CFG_DATA_BITS-1:0] d
    );
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_reg(idx, d);
        reg_writes++;
    endtask

    task automatic program_all(
        input logic [CFG_DATA_BITS-1:0] dl,
        input logic [CFG_DATA_BITS-1:0] dr,
        input logic [CFG_DATA_BITS-1:0] fb,
        input logic [CFG_DATA_BITS-1:0] depth,
        input logic [CFG_DATA_BITS-1:0] mix,
        input logic [CFG_DATA_BITS-1:0] step
    );
        write_reg(REG_DELAY_LEFT, dl);
        write_reg(REG_DELAY_RIGHT, dr);
        write_reg(REG_FEEDBACK_GAIN, fb);
        write_reg(REG_MOD_DEPTH, depth);
        write_reg(REG_MIX_GAIN, mix);
        write_reg(REG_LFO_STEP, step);
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // wait until every queued item is taken and every output has come back
    task automatic drain();
        while (accepted_count != queued_count || expected_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] rand_delay();
        logic [CFG_DATA_BITS-1:0] v;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = CFG_DATA_BITS'(COMB_DEPTH - 1);
            2, 3:    v = CFG_DATA_BITS'($urandom_range(COMB_DEPTH - 1));
            default: v = CFG_DATA_BITS'($urandom_range(300, 1));
        endcase
        if ($urandom_range(1))
        begin
            v = v | (CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'(COMB_DEPTH - 1));
        end
        return v;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_mix();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CFG_DATA_BITS'(WET_FULL);
            2:       return CFG_DATA_BITS'($urandom_range(65535, WET_FULL + 1));
            default: return CFG_DATA_BITS'($urandom_range(WET_FULL));
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d outputs still expected", $time, expected_pairs.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : driver
        stereo_pair_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            left_sample <= '0;
            right_sample <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                flange_step(left_sample, right_sample);
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_pairs.pop_front();
                    left_sample <= nxt.left;
                    right_sample <= nxt.right;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        stereo_pair_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual L=%0d R=%0d",
                             $time, left_out, right_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (left_out !== want.left)
                    begin
                        $display("%0t: left_out expected %0d actual %0d",
                                 $time, want.left, left_out);
                        mismatches++;
                    end
                    if (right_out !== want.right)
                    begin
                        $display("%0t: right_out expected %0d actual %0d",
                                 $time, want.right, right_out);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_seen != hold_request)
            begin
                hold_seen = hold_request;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial
    begin
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            sine_lut[k] = sine_q15(k);
        end
        for (int k = 0; k < COMB_DEPTH; k++)
        begin
            ring_l[k] = '0;
            ring_r[k] = '0;
        end
        wr_ptr = '0;
        lfo_acc = '0;
        cfg_delay_l = DEF_DELAY_L;
        cfg_delay_r = DEF_DELAY_R;
        cfg_fb = DEF_FB;
        cfg_depth = DEF_DEPTH;
        cfg_mix = DEF_MIX;
        cfg_step = DEF_STEP;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, sample extremes
        queue_item(S_MAX, S_MIN);
        queue_item(S_MIN, S_MAX);
        queue_item('0, '0);
        queue_item('1, 24'sd1);
        queue_item(24'h555555, 24'hAAAAAA);
        queue_item(S_MAX, S_MAX);
        queue_item(S_MIN, S_MIN);
        drain();

        // ignored indexes, mix above unity, zero left delay, full gains and step
        write_reg(REG_NONE_LO, '1);
        write_reg(REG_NONE_HI, '1);
        program_all('0, CFG_DATA_BITS'(COMB_DEPTH - 1), 24'd32767, 24'd32767, 24'd65535,
                    24'hFFFFFF);
        for (int i = 0; i < 4; i++)
        begin
            queue_item(S_MAX, S_MIN);
            queue_item(S_MIN, S_MAX);
        end
        drain();

        // opposite corner: long left, zero right, no feedback, no sweep, all wet
        program_all(CFG_DATA_BITS'(COMB_DEPTH - 1), '0, '0, '0, CFG_DATA_BITS'(WET_FULL), '0);
        queue_item(S_MAX, S_MIN);
        queue_item(S_MIN, S_MAX);
        queue_item(24'h123456, 24'hEDCBA9);
        queue_item('1, '0);
        queue_item('0, '1);
        queue_item(S_MAX, S_MAX);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            program_all(rand_delay(), rand_delay(), CFG_DATA_BITS'(pick(0, 32767)),
                        CFG_DATA_BITS'(pick(0, 32767)), rand_mix(),
                        ($urandom_range(1) != 0) ? CFG_DATA_BITS'(pick(0, 24'hFFFFFF))
                                                 : CFG_DATA_BITS'(pick(0, 2000)));
            if (seg < 3)
            begin
                send_idle_pct = 32;
                recv_stall_pct = 67;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 67;
                recv_stall_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                queue_item(rand_sample(), rand_sample());
            end
            if (seg == 1 || seg == 6)
            begin
                hold_request++;
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("run covered %0d stereo items and %0d outputs across %0d settings (%0d writes)",
                 accepted_count, results_seen, setting_count, reg_writes);
        $display("idle mixes 32/67, 67/32 and none, with two long output holds");
        if (mismatches == 0 && expected_pairs.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches, %0d outputs never seen", mismatches, expected_pairs.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
